### design/qedc_pkg.sv
// package of types, codes and the phase transition table for the quadrature edge decoder
`default_nettype none

package qedc_pkg;

    // widths of the payload
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned STEP_W  = 2;

    typedef logic [1:0]                 phase_t;
    typedef logic [2:0]                 act_t;
    typedef logic [1:0]                 event_t;
    typedef logic [STEP_W-1:0]          step_t;
    typedef logic signed [COUNT_W-1:0]  count_t;

    // item function codes
    localparam logic FUNC_EDGE = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    // encoder phases
    localparam phase_t PHASE_REST     = 2'd0;
    localparam phase_t PHASE_A_LOW    = 2'd1;
    localparam phase_t PHASE_BOTH_LOW = 2'd2;
    localparam phase_t PHASE_B_LOW    = 2'd3;

    // edge events, coded as {line_is_b, falling}
    localparam event_t EV_A_RISE = 2'd0;
    localparam event_t EV_A_FALL = 2'd1;
    localparam event_t EV_B_RISE = 2'd2;
    localparam event_t EV_B_FALL = 2'd3;

    // table actions
    localparam act_t ACT_NONE    = 3'd0;
    localparam act_t ACT_CLEAR   = 3'd1;
    localparam act_t ACT_ARM_CW  = 3'd2;
    localparam act_t ACT_ARM_CCW = 3'd3;
    localparam act_t ACT_CW      = 3'd4;
    localparam act_t ACT_CCW     = 3'd5;

    // step codes
    localparam step_t STEP_NONE = 2'b00;
    localparam step_t STEP_CW   = 2'b01;
    localparam step_t STEP_CCW  = 2'b11;

    typedef struct packed {
        phase_t next;
        act_t   act;
    } trans_t;

    // one input beat
    typedef struct packed {
        logic   func;
        logic   line_is_b;
        logic   rising;
        count_t load_value;
    } item_t;

    // decoder state
    typedef struct packed {
        phase_t phase;
        logic   cw_armed;
        logic   ccw_armed;
        count_t position;
    } dec_state_t;

    // phase transition table
    function automatic trans_t trans_lookup(input phase_t ph, input event_t ev);
        trans_t t;
        t.next = PHASE_REST;
        t.act  = ACT_NONE;
        case ({ph, ev})
            {PHASE_REST, EV_A_RISE}:     begin t.next = PHASE_REST;     t.act = ACT_CLEAR;   end
            {PHASE_REST, EV_A_FALL}:     begin t.next = PHASE_A_LOW;    t.act = ACT_ARM_CW;  end
            {PHASE_REST, EV_B_RISE}:     begin t.next = PHASE_REST;     t.act = ACT_CLEAR;   end
            {PHASE_REST, EV_B_FALL}:     begin t.next = PHASE_B_LOW;    t.act = ACT_ARM_CCW; end
            {PHASE_A_LOW, EV_A_RISE}:    begin t.next = PHASE_REST;     t.act = ACT_CCW;     end
            {PHASE_A_LOW, EV_A_FALL}:    begin t.next = PHASE_A_LOW;    t.act = ACT_NONE;    end
            {PHASE_A_LOW, EV_B_RISE}:    begin t.next = PHASE_A_LOW;    t.act = ACT_NONE;    end
            {PHASE_A_LOW, EV_B_FALL}:    begin t.next = PHASE_BOTH_LOW; t.act = ACT_NONE;    end
            {PHASE_BOTH_LOW, EV_A_RISE}: begin t.next = PHASE_B_LOW;    t.act = ACT_NONE;    end
            {PHASE_BOTH_LOW, EV_A_FALL}: begin t.next = PHASE_BOTH_LOW; t.act = ACT_NONE;    end
            {PHASE_BOTH_LOW, EV_B_RISE}: begin t.next = PHASE_A_LOW;    t.act = ACT_NONE;    end
            {PHASE_BOTH_LOW, EV_B_FALL}: begin t.next = PHASE_BOTH_LOW; t.act = ACT_NONE;    end
            {PHASE_B_LOW, EV_A_RISE}:    begin t.next = PHASE_B_LOW;    t.act = ACT_NONE;    end
            {PHASE_B_LOW, EV_A_FALL}:    begin t.next = PHASE_BOTH_LOW; t.act = ACT_NONE;    end
            {PHASE_B_LOW, EV_B_RISE}:    begin t.next = PHASE_REST;     t.act = ACT_CW;      end
            {PHASE_B_LOW, EV_B_FALL}:    begin t.next = PHASE_B_LOW;    t.act = ACT_NONE;    end
            default:                     begin t.next = PHASE_REST;     t.act = ACT_NONE;    end
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

### design/qedc_step.sv
// next-state and step logic of the quadrature decoder for one beat
`default_nettype none

module qedc_step (
    input  wire qedc_pkg::item_t      item,
    input  wire qedc_pkg::dec_state_t cur,
    output qedc_pkg::dec_state_t      nxt,
    output qedc_pkg::step_t           step
);

    qedc_pkg::trans_t trans;
    qedc_pkg::event_t ev;

    // event code: line in the upper bit, falling in the lower bit
    assign ev    = {item.line_is_b, ~item.rising};
    assign trans = qedc_pkg::trans_lookup(cur.phase, ev);

    // apply the table action, or the load
    always_comb
    begin
        nxt  = cur;
        step = qedc_pkg::STEP_NONE;
        if (item.func == qedc_pkg::FUNC_LOAD)
        begin
            nxt.position = item.load_value;
        end
        else
        begin
            case (trans.act)
                qedc_pkg::ACT_CLEAR:
                begin
                    nxt.cw_armed  = 1'b0;
                    nxt.ccw_armed = 1'b0;
                end
                qedc_pkg::ACT_ARM_CW:
                begin
                    if (!cur.cw_armed)
                    begin
                        nxt.cw_armed  = 1'b1;
                        nxt.ccw_armed = 1'b0;
                    end
                end
                qedc_pkg::ACT_ARM_CCW:
                begin
                    if (!cur.ccw_armed)
                    begin
                        nxt.ccw_armed = 1'b1;
                        nxt.cw_armed  = 1'b0;
                    end
                end
                qedc_pkg::ACT_CW:
                begin
                    if (cur.cw_armed)
                    begin
                        nxt.position  = cur.position + qedc_pkg::count_t'(1);
                        step          = qedc_pkg::STEP_CW;
                        nxt.cw_armed  = 1'b0;
                        nxt.ccw_armed = 1'b0;
                    end
                end
                qedc_pkg::ACT_CCW:
                begin
                    if (cur.ccw_armed)
                    begin
                        nxt.position  = cur.position - qedc_pkg::count_t'(1);
                        step          = qedc_pkg::STEP_CCW;
                        nxt.cw_armed  = 1'b0;
                        nxt.ccw_armed = 1'b0;
                    end
                end
                default:
                begin
                    nxt = cur;
                end
            endcase
            nxt.phase = trans.next;
        end
    end

endmodule

`default_nettype wire

### design/quadrature_edge_decoder_counter.sv
// top level of the quadrature edge decoder with position counter
`default_nettype none

// Each input beat is an edge event on encoder line A or B, or a load of the
// position count; each one yields exactly one result beat with the count after
// it and the step it applied (+1, -1 or 0). The block takes one beat per
// cycle while the output is not stalled: a beat sits in the input register
// while the phase table and the 32-bit count update work on it, and its
// result then moves into the output register. The decoder state advances as
// a beat moves into the output register, so back-to-back beats see each
// other's updates. in_ready follows out_ready combinationally; a stalled
// output holds its beat and, once the input register is also full, the
// input side stalls too.

module quadrature_edge_decoder_counter (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire                     func,
    input  wire                     line_is_b,
    input  wire                     rising,
    input  wire qedc_pkg::count_t   load_value,
    output logic                    out_valid,
    input  wire                     out_ready,
    output qedc_pkg::count_t        count,
    output qedc_pkg::step_t         step
);

    logic                 s1_valid_reg;
    qedc_pkg::item_t      s1_item_reg;
    qedc_pkg::dec_state_t state_reg;
    qedc_pkg::dec_state_t state_next;
    qedc_pkg::step_t      step_next;
    logic                 out_valid_reg;
    qedc_pkg::count_t     count_reg;
    qedc_pkg::step_t      step_reg;
    logic                 advance;

    // handshake
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg <= '{func: func, line_is_b: line_is_b, rising: rising,
                             load_value: load_value};
        end
    end

    // decode logic
    qedc_step u_step (
        .item (s1_item_reg),
        .cur  (state_reg),
        .nxt  (state_next),
        .step (step_next)
    );

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{phase: qedc_pkg::PHASE_REST, cw_armed: 1'b0, ccw_armed: 1'b0,
                           position: '0};
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            count_reg <= state_next.position;
            step_reg  <= step_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign count     = count_reg;
    assign step      = step_reg;

endmodule

`default_nettype wire

### design/qedc_checker.sv
// port-level checks of the quadrature edge decoder, bound to the top level
`default_nettype none

module qedc_port_checks (
    input wire                   clk,
    input wire                   rst_n,
    input wire                   in_valid,
    input wire                   in_ready,
    input wire                   out_valid,
    input wire                   out_ready,
    input wire qedc_pkg::count_t count,
    input wire qedc_pkg::step_t  step
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(count) && $stable(step))
        else $error("result beat changed while stalled");

    // only the three legal step codes appear
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (step == qedc_pkg::STEP_NONE || step == qedc_pkg::STEP_CW ||
                       step == qedc_pkg::STEP_CCW))
        else $error("illegal step code");

    // with the output side empty the block always takes a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // an accepted beat is followed by out_valid being high
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> ##1 out_valid)
        else $error("no result two cycles after accepted beat");

endmodule

bind quadrature_edge_decoder_counter qedc_port_checks u_qedc_checker (.*);

`default_nettype wire
